// File: src/spq_pkg.sv
// ============================================================================
// spq_pkg: shared types and constants of the sorted priority queue
// Sizes, operation and status codes, and the entry and operation structs
// that pass between the top level and the row of queue cells.
// ============================================================================
package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int PRIO_W        = 32;
  localparam int WORD_W        = 32;
  localparam int COUNT_W       = $clog2(DEPTH + 1);

  localparam logic signed [PRIO_W-1:0] PRIO_MAX = {1'b0, {(PRIO_W-1){1'b1}}};
  localparam logic signed [PRIO_W-1:0] PRIO_MIN = {1'b1, {(PRIO_W-1){1'b0}}};

  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_PEEK = 2'd2,
    MODE_ADD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // One stored entry as a cell holds it.
  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } entry_t;

  // Operation broadcast to every cell in the cycle a transaction is taken.
  typedef struct packed {
    logic                     en;
    mode_t                    mode;
    logic signed [PRIO_W-1:0] prio;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic signed [PRIO_W-1:0] delta;
  } cell_op_t;

endpackage

// File: src/spq_req_if.sv
// ============================================================================
// spq_req_if: request channel of the sorted priority queue
// Valid/ready channel that carries one queue operation per transaction.
// ============================================================================
interface spq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           mode;
  logic [spq_pkg::WORD_W-1:0]           payload;
  logic signed [spq_pkg::PRIO_W-1:0]    priority_req;
  logic signed [spq_pkg::PRIO_W-1:0]    delta;

  modport source (output valid, mode, payload, priority_req, delta, input ready);
  modport sink   (input valid, mode, payload, priority_req, delta, output ready);
endinterface

// File: src/spq_rsp_if.sv
// ============================================================================
// spq_rsp_if: response channel of the sorted priority queue
// Valid/ready channel that carries one result per transaction.
// ============================================================================
interface spq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [spq_pkg::WORD_W-1:0]           out_payload;
  logic signed [spq_pkg::PRIO_W-1:0]    out_priority;
  logic [1:0]                           status;
  logic [spq_pkg::COUNT_W-1:0]          count;
  logic                                 is_empty;

  modport source (output valid, out_payload, out_priority, status, count, is_empty,
                  input ready);
  modport sink   (input valid, out_payload, out_priority, status, count, is_empty,
                  output ready);
endinterface

// File: src/spq_cell.sv
// ============================================================================
// spq_cell: one slot of the sorted queue
// Holds one entry and, per operation, keeps it, takes the new entry, takes
// the left or right neighbour's entry, or adds the delta with saturation.
// ============================================================================
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::cell_op_t op,
  input  spq_pkg::entry_t   left,
  input  logic              left_keep,
  input  spq_pkg::entry_t   right,
  output spq_pkg::entry_t   entry,
  output logic              keep
);

  spq_pkg::entry_t                   entry_next;
  logic signed [spq_pkg::PRIO_W:0]   sum;
  logic signed [spq_pkg::PRIO_W-1:0] sat;

  // An entry stays put on insert when it sorts at or before the new one,
  // which keeps equal priorities in arrival order.
  assign keep = entry.valid && ($signed(entry.prio) <= $signed(op.prio));

  always_comb begin
    sum = {entry.prio[spq_pkg::PRIO_W-1], entry.prio} +
          {op.delta[spq_pkg::PRIO_W-1], op.delta};
    if (sum[spq_pkg::PRIO_W] != sum[spq_pkg::PRIO_W-1]) begin
      sat = sum[spq_pkg::PRIO_W] ? spq_pkg::PRIO_MIN : spq_pkg::PRIO_MAX;
    end else begin
      sat = sum[spq_pkg::PRIO_W-1:0];
    end
  end

  always_comb begin
    entry_next = entry;
    if (op.en) begin
      case (op.mode)
        spq_pkg::MODE_ENQ: begin
          if (!keep) begin
            if (left_keep) begin
              entry_next.valid   = 1'b1;
              entry_next.prio    = op.prio;
              entry_next.payload = op.payload;
            end else begin
              entry_next = left;
            end
          end
        end
        spq_pkg::MODE_DEQ: begin
          entry_next = right;
        end
        spq_pkg::MODE_ADD: begin
          if (entry.valid) begin
            entry_next.prio = sat;
          end
        end
        default: begin
          entry_next = entry;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry.prio    <= entry_next.prio;
    entry.payload <= entry_next.payload;
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
  end

endmodule

// File: src/sorted_priority_queue.sv
// ============================================================================
// sorted_priority_queue: sorted-list priority queue built from a cell row
// Keeps up to DEPTH entries ordered by ascending signed priority and serves
// enqueue, dequeue, peek and add-to-all operations with one result each.
// ============================================================================
// On every accepted request the operation is broadcast to a row of DEPTH
// identical cells, each of which compares its own priority against the new
// one and hands its entry to a neighbour, so insert, remove and add-delta
// are all applied by the cell registers themselves with no extra pass, and
// a new request is taken every cycle while the response register is free
// or being emptied. Entries of equal priority keep their arrival order,
// because an entry stays put on insert when its priority is less than or
// equal to the new one. Adding a delta saturates each priority at the
// 32-bit signed limits, which preserves the order. An enqueue into a full
// queue drops the entry and reports full status; a dequeue or peek on an
// empty queue reports empty status with zero payload and priority. The
// response also carries the entry count and an empty flag after the
// operation. There is no clearing pass: reset only clears the valid flags
// of the cells, the count and the response valid flag, so the queue is
// usable as soon as reset is released.
module sorted_priority_queue (
  input  logic     clk,
  input  logic     rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  localparam int DEPTH = spq_pkg::DEPTH;

  spq_pkg::entry_t   cells [DEPTH];
  logic [DEPTH-1:0]  keeps;
  spq_pkg::cell_op_t op;

  logic [spq_pkg::COUNT_W-1:0] count;
  logic [spq_pkg::COUNT_W-1:0] count_next;

  spq_pkg::mode_t mode;
  logic           fire;
  logic           full;
  logic           empty;
  logic           read_ok;

  // The response register frees up when it is empty or being taken, so a
  // waiting result that is not being taken holds off the next request.
  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign mode      = spq_pkg::mode_t'(req.mode);
  assign full      = (count == spq_pkg::COUNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign read_ok   = ((mode == spq_pkg::MODE_DEQ) || (mode == spq_pkg::MODE_PEEK)) && !empty;

  // The operation is withheld from the cells when it is not legal: an
  // enqueue on a full queue and a dequeue on an empty queue leave them alone.
  always_comb begin
    op.en      = fire &&
                 !((mode == spq_pkg::MODE_ENQ) && full) &&
                 !((mode == spq_pkg::MODE_DEQ) && empty);
    op.mode    = mode;
    op.prio    = req.priority_req;
    op.payload = spq_pkg::PAYLOAD_WIDTH'(req.payload);
    op.delta   = req.delta;
  end

  always_comb begin
    count_next = count;
    if (op.en && (mode == spq_pkg::MODE_ENQ)) begin
      count_next = count + 1'b1;
    end else if (op.en && (mode == spq_pkg::MODE_DEQ)) begin
      count_next = count - 1'b1;
    end
  end

  // The row of cells. The head cell sees a left neighbour that always keeps,
  // so a new entry lands there when the head entry sorts after it; the tail
  // cell sees an empty right neighbour, which a dequeue shifts in.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left;
    spq_pkg::entry_t right;
    logic            left_keep;

    if (i == 0) begin : g_head
      assign left      = '0;
      assign left_keep = 1'b1;
    end else begin : g_body
      assign left      = cells[i-1];
      assign left_keep = keeps[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .left      (left),
      .left_keep (left_keep),
      .right     (right),
      .entry     (cells[i]),
      .keep      (keeps[i])
    );
  end

  // Count and response register. The front entry is read from the head cell
  // before this cycle's update takes effect.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
    if (fire) begin
      rsp.out_payload  <= read_ok ? spq_pkg::WORD_W'(cells[0].payload) : '0;
      rsp.out_priority <= read_ok ? cells[0].prio : '0;
      if ((mode == spq_pkg::MODE_ENQ) && full) begin
        rsp.status <= spq_pkg::STATUS_FULL;
      end else if (((mode == spq_pkg::MODE_DEQ) || (mode == spq_pkg::MODE_PEEK)) && empty) begin
        rsp.status <= spq_pkg::STATUS_EMPTY;
      end else begin
        rsp.status <= spq_pkg::STATUS_OK;
      end
      rsp.count    <= count_next;
      rsp.is_empty <= (count_next == '0);
    end
  end

endmodule
